[hdl/path_point_search_defines.svh]
// ----------------------------------------------------------------------------
// Path point search assertion macros
// Shared property forms for the checkers of the path point search block.
// ----------------------------------------------------------------------------
`ifndef PATH_POINT_SEARCH_DEFINES_SVH
`define PATH_POINT_SEARCH_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("path_point_search check failed");

// next-cycle implication, quiet during reset
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("path_point_search check failed");

`endif

[hdl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// Path point search package
// Payload types, command and status groups, and codes of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int CSR_INDEX_W = 1;
   localparam int RADIUS_W    = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOKAHEAD_RADIUS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_RADIUS     = 1'd1;
   localparam logic [RADIUS_W-1:0] LOOKAHEAD_RADIUS_RESET = 15'd500;
   localparam logic [RADIUS_W-1:0] POINT_RADIUS_RESET     = 15'd50;

   localparam int DIST_W = 33;
   localparam int POINT_W = 48;

   typedef struct packed {
      logic [1:0]          req_type;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic signed [15:0]  point_velocity;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0]  closest_x;
      logic signed [15:0]  closest_y;
      logic signed [15:0]  closest_velocity;
      logic                closest_valid;
      logic signed [15:0]  look_x;
      logic signed [15:0]  look_y;
      logic                look_found;
      logic [1:0]          status;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0]  velocity;
      logic signed [15:0]  y;
      logic signed [15:0]  x;
   } point_type;

   typedef struct packed {
      logic accept;
      logic close_start;
      logic take_best;
      logic advance;
      logic look_start;
      logic look_take;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
      logic farther;
      logic meet;
      logic look_end;
   } stat_type;

endpackage

[hdl/pps_ram.sv]
// ----------------------------------------------------------------------------
// Path point search RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pps_ctrl.sv]
// ----------------------------------------------------------------------------
// Path point search controller
// Sequences request handling, the closest walk and the lookahead walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pps_pkg::stat_type st,
   output pps_pkg::cmd_type  cmd
);
   import pps_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SUB    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_ADD    = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_LOOK   = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_CAND  = 2'd1;
   localparam logic [1:0] PH_LOOK  = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_kind == REQ_QUERY && !st.empty) begin
                  cmd.close_start = 1'b1;
                  phase_in        = PH_FIRST;
                  state_in        = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_READ:  state_in = S_SUB;
         S_SUB:   state_in = S_MUL;
         S_MUL:   state_in = S_ADD;
         S_ADD:   state_in = S_DECIDE;
         S_DECIDE: begin
            priority if (phase_ff == PH_LOOK) begin
               cmd.look_take = 1'b1;
               if (st.meet || st.last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else if (phase_ff == PH_CAND && st.farther) begin
               state_in = S_LOOK;
            end else begin
               cmd.take_best = 1'b1;
               if (st.last) begin
                  state_in = S_LOOK;
               end else begin
                  cmd.advance = 1'b1;
                  phase_in    = PH_CAND;
                  state_in    = S_READ;
               end
            end
         end
         S_LOOK: begin
            cmd.look_start = 1'b1;
            if (st.look_end) begin
               state_in = S_FINISH;
            end else begin
               phase_in = PH_LOOK;
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/pps_datapath.sv]
// ----------------------------------------------------------------------------
// Path point search datapath
// Path store, indices, radius registers, distance pipe and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_datapath #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pps_pkg::req_payload_type             req_payload,
   input  logic                                 csr_valid,
   input  logic [pps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pps_pkg::RADIUS_W-1:0]         csr_data,
   input  pps_pkg::cmd_type                     cmd,
   output pps_pkg::stat_type                    st,
   output pps_pkg::rsp_payload_type             rsp_payload
);
   import pps_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   closest_ff, closest_in;
   logic [CNT_W-1:0]    look_ff, look_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [RADIUS_W-1:0] la_radius_ff, la_radius_in;
   logic [RADIUS_W-1:0] pt_radius_ff, pt_radius_in;

   logic signed [15:0]  px_ff, py_ff;
   logic [DIST_W-1:0]   best_d_ff;
   logic [15:0]         dx_ff, dy_ff;
   logic [31:0]         sqx_ff, sqy_ff;
   logic [DIST_W-1:0]   d2_ff;
   logic [15:0]         rsum_ff;
   logic [14:0]         rdif_ff;
   logic [31:0]         rsum_sq_ff;
   logic [29:0]         rdif_sq_ff;
   rsp_payload_type     res_ff, res_in;
   rsp_payload_type     rsp_ff;

   logic                wr_en;
   point_type           wr_point;
   logic [POINT_W-1:0]  rd_data;
   point_type           pt;
   logic                full;
   logic [CNT_W-1:0]    idx_next;
   logic [CNT_W-1:0]    look_clamp;
   logic [ADDR_W-1:0]   close_clamp;
   logic signed [16:0]  dx_raw, dy_raw;

   assign full     = (count_ff == CNT_W'(MAX_POINTS));
   assign wr_en    = cmd.accept && req_payload.req_type == REQ_APPEND && !full;
   assign wr_point = '{velocity: req_payload.point_velocity,
                       y: req_payload.pos_y, x: req_payload.pos_x};

   pps_ram #(
      .WIDTH(POINT_W),
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(wr_point),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign pt          = point_type'(rd_data);
   assign idx_next    = CNT_W'({1'b0, idx_ff}) + CNT_W'(1);
   assign look_clamp  = (look_ff > count_ff) ? count_ff : look_ff;
   assign close_clamp = (CNT_W'(closest_ff) >= count_ff) ?
                        ADDR_W'(count_ff - CNT_W'(1)) : closest_ff;

   assign st.empty    = (count_ff == '0);
   assign st.last     = (idx_next >= count_ff);
   assign st.farther  = (d2_ff > best_d_ff);
   assign st.meet     = !(d2_ff == '0 && la_radius_ff == pt_radius_ff) &&
                        (DIST_W'(rdif_sq_ff) <= d2_ff) && (d2_ff < DIST_W'(rsum_sq_ff));
   assign st.look_end = (look_clamp >= count_ff);

   always_comb begin
      count_in     = count_ff;
      closest_in   = closest_ff;
      look_in      = look_ff;
      idx_in       = idx_ff;
      la_radius_in = la_radius_ff;
      pt_radius_in = pt_radius_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOOKAHEAD_RADIUS: la_radius_in = csr_data;
            CSR_POINT_RADIUS:     pt_radius_in = csr_data;
            default: ;
         endcase
      end
      if (cmd.accept) begin
         if (req_payload.req_type == REQ_CLEAR) begin
            count_in   = '0;
            closest_in = '0;
            look_in    = '0;
         end
         if (wr_en) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.close_start) begin
         idx_in = close_clamp;
      end
      if (cmd.take_best) begin
         closest_in = idx_ff;
      end
      if (cmd.look_start) begin
         look_in = look_clamp;
         idx_in  = look_clamp[ADDR_W-1:0];
      end
      if (cmd.look_take) begin
         look_in = idx_next;
      end
      if (cmd.advance) begin
         idx_in = idx_next[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closest_ff   <= '0;
         look_ff      <= '0;
         idx_ff       <= '0;
         la_radius_ff <= LOOKAHEAD_RADIUS_RESET;
         pt_radius_ff <= POINT_RADIUS_RESET;
      end else begin
         count_ff     <= count_in;
         closest_ff   <= closest_in;
         look_ff      <= look_in;
         idx_ff       <= idx_in;
         la_radius_ff <= la_radius_in;
         pt_radius_ff <= pt_radius_in;
      end
   end

   assign dx_raw = {px_ff[15], px_ff} - {pt.x[15], pt.x};
   assign dy_raw = {py_ff[15], py_ff} - {pt.y[15], pt.y};

   always_ff @(posedge clock) begin
      dx_ff      <= dx_raw[16] ? 16'(-dx_raw) : dx_raw[15:0];
      dy_ff      <= dy_raw[16] ? 16'(-dy_raw) : dy_raw[15:0];
      sqx_ff     <= dx_ff * dx_ff;
      sqy_ff     <= dy_ff * dy_ff;
      d2_ff      <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
      rsum_ff    <= 16'(la_radius_ff) + 16'(pt_radius_ff);
      rdif_ff    <= (la_radius_ff >= pt_radius_ff) ? la_radius_ff - pt_radius_ff :
                                                     pt_radius_ff - la_radius_ff;
      rsum_sq_ff <= rsum_ff * rsum_ff;
      rdif_sq_ff <= rdif_ff * rdif_ff;
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.accept) begin
         res_in = '0;
         if (req_payload.req_type == REQ_APPEND && full) begin
            res_in.status = STATUS_FULL;
         end
         if (req_payload.req_type == REQ_QUERY && count_ff == '0) begin
            res_in.status = STATUS_EMPTY;
         end
      end
      if (cmd.close_start) begin
         res_in.closest_valid = 1'b1;
      end
      if (cmd.take_best) begin
         res_in.closest_x        = pt.x;
         res_in.closest_y        = pt.y;
         res_in.closest_velocity = pt.velocity;
      end
      if (cmd.look_take && st.meet) begin
         res_in.look_x     = pt.x;
         res_in.look_y     = pt.y;
         res_in.look_found = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= req_payload.pos_x;
         py_ff <= req_payload.pos_y;
      end
      if (cmd.take_best) begin
         best_d_ff <= d2_ff;
      end
      res_ff <= res_in;
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[hdl/path_point_search.sv]
// Path point search keeps a path of up to MAX_POINTS points in one RAM and
// answers one result beat for every request beat. Clear, append, unused codes
// and queries on an empty path go from the idle state straight to the finish
// state, which loads the output register. A query visits path points one at a
// time; each visit passes through the RAM read and the subtract, square and
// add registers of the distance pipe, then the decide state. A new request
// beat is taken once the previous result sits in the output register; radius
// writes are taken every cycle. The path store needs no clearing pass after
// reset.
// ----------------------------------------------------------------------------
// Path point search top level
// Joins the controller and the datapath and drives the CSR handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_point_search #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pps_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pps_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pps_pkg::RADIUS_W-1:0]      csr_data
);
   import pps_pkg::*;

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_payload.req_type),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .st       (st),
      .cmd      (cmd)
   );

   pps_datapath #(
      .MAX_POINTS(MAX_POINTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .st         (st),
      .rsp_payload(rsp_payload)
   );

endmodule

[hdl/pps_checker.sv]
// ----------------------------------------------------------------------------
// Path point search checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "path_point_search_defines.svh"

module pps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pps_pkg::rsp_payload_type  rsp_payload
);
   import pps_pkg::*;

   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PPS_ASSERT_NOW(a_fail_no_find, clock, reset, rsp_valid && rsp_payload.status != STATUS_OK, !rsp_payload.closest_valid && !rsp_payload.look_found)
   `PPS_ASSERT_NOW(a_look_zero, clock, reset, rsp_valid && !rsp_payload.look_found, rsp_payload.look_x == 16'sd0 && rsp_payload.look_y == 16'sd0)
   `PPS_ASSERT_NOW(a_look_needs_close, clock, reset, rsp_valid && rsp_payload.look_found, rsp_payload.closest_valid)

endmodule

bind path_point_search pps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);
